[rtl/sds_pkg.sv]
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants of the SCAN disk scheduler
// Command and status bundles between controller and datapath, field widths
// and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package sds_pkg;

  localparam int POS_W     = 12;   // cylinder number
  localparam int MOV_W     = 13;   // accumulated head movement
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;
  localparam int IN_DAT_W  = 16;   // request_cylinder padded to bytes
  localparam int OUT_DAT_W = 32;   // served_position + movement_so_far padded

  localparam logic [CFG_IDX_W-1:0] REG_START_HEAD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_UP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CYLINDER = 2'd2;

  localparam logic [POS_W-1:0] START_HEAD_RST = 12'd0;
  localparam logic             SWEEP_UP_RST   = 1'b1;
  localparam logic [POS_W-1:0] MAX_CYL_RST    = 12'd199;
  localparam logic [POS_W-1:0] LOW_END_STOP   = 12'd0;

  // controller -> datapath
  typedef struct packed {
    logic ins_start;   // item accepted: latch request, aim at the tail
    logic ins_shift;   // move one larger entry up by one slot
    logic ins_place;   // write the request at the insert slot
    logic scan_start;  // begin counting entries below the head
    logic scan_cmp;    // count the entry just read
    logic mem_rd;      // read the entry at the walk index
    logic seg_asc;     // walk index to the first upper entry
    logic seg_desc;    // walk index to the last lower entry
    logic idx_inc;
    logic idx_dec;
    logic vis_load;    // load a request visit into the output register
    logic vis_end;     // load an end stop visit into the output register
    logic vis_final;   // the loaded visit closes the schedule
    logic clear;       // empty the store
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic pos_one;
    logic rdata_gt_v;
    logic last_req;
    logic split_zero;
    logic split_full;
    logic idx_top;
    logic idx_zero;
    logic out_free;
    logic sweep_up;
  } sts_t;

endpackage

`default_nettype wire

[rtl/sds_dp.sv]
// ----------------------------------------------------------------------------
// sds_dp: SCAN scheduler datapath
// Sorted request memory, configuration registers, walk counters, movement
// accumulator and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_dp #(
  parameter int MAX_REQUESTS = 32
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire sds_pkg::cmd_t            cmd,
  output sds_pkg::sts_t                 sts,
  input  wire                           cfg_we,
  input  wire [sds_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire [sds_pkg::CFG_DAT_W-1:0]  cfg_dat,
  input  wire [sds_pkg::POS_W-1:0]      req_cyl,
  input  wire                           req_last,
  input  wire                           out_ready,
  output logic                          out_valid,
  output logic [sds_pkg::POS_W-1:0]     out_pos,
  output logic                          out_end,
  output logic [sds_pkg::MOV_W-1:0]     out_mov,
  output logic                          out_last
);

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  logic [sds_pkg::POS_W-1:0] mem [MAX_REQUESTS];

  logic [sds_pkg::POS_W-1:0] start_head_r, max_cyl_r;
  logic                      sweep_up_r;
  logic [sds_pkg::POS_W-1:0] rdata_r, v_r, head_r;
  logic                      last_r;
  logic [IDX_W-1:0]          pos_r;
  logic [CNT_W-1:0]          count_r, split_r, idx_r;
  logic [sds_pkg::MOV_W-1:0] mov_r;
  logic                      out_valid_r, out_end_r, out_last_r;
  logic [sds_pkg::POS_W-1:0] out_pos_r;
  logic [sds_pkg::MOV_W-1:0] out_mov_r;

  logic [CNT_W-1:0]          count_m1;
  logic [IDX_W-1:0]          rd_addr;
  logic                      rd_en;
  logic [sds_pkg::POS_W-1:0] clamp_v, vis_pos, seek_len;
  logic                      below_head;

  assign count_m1 = count_r - CNT_W'(1);
  assign clamp_v  = (req_cyl > max_cyl_r) ? max_cyl_r : req_cyl;

  always_comb begin
    rd_addr = idx_r[IDX_W-1:0];
    if (cmd.ins_start) begin
      rd_addr = count_m1[IDX_W-1:0];
    end else if (cmd.ins_shift) begin
      rd_addr = pos_r - IDX_W'(2);
    end
  end
  assign rd_en = cmd.ins_start | cmd.ins_shift | cmd.mem_rd;

  // sorted store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.ins_shift) begin
      mem[pos_r] <= rdata_r;
    end else if (cmd.ins_place) begin
      mem[pos_r] <= v_r;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // upward sweeps serve entries at or above the head, downward at or below
  assign below_head = sweep_up_r ? (rdata_r < start_head_r) : (rdata_r <= start_head_r);

  always_comb begin
    vis_pos = rdata_r;
    if (cmd.vis_end) begin
      vis_pos = sweep_up_r ? max_cyl_r : sds_pkg::LOW_END_STOP;
    end
    seek_len = (vis_pos >= head_r) ? (vis_pos - head_r) : (head_r - vis_pos);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_head_r <= sds_pkg::START_HEAD_RST;
      sweep_up_r   <= sds_pkg::SWEEP_UP_RST;
      max_cyl_r    <= sds_pkg::MAX_CYL_RST;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          sds_pkg::REG_START_HEAD:   start_head_r <= cfg_dat;
          sds_pkg::REG_SWEEP_UP:     sweep_up_r   <= cfg_dat[0];
          sds_pkg::REG_MAX_CYLINDER: max_cyl_r    <= cfg_dat;
          default: ;
        endcase
      end
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.ins_place) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.vis_load || cmd.vis_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_start) begin
      v_r    <= clamp_v;
      last_r <= req_last;
      pos_r  <= count_r[IDX_W-1:0];
    end else if (cmd.ins_shift) begin
      pos_r <= pos_r - IDX_W'(1);
    end
    if (cmd.scan_start) begin
      split_r <= '0;
      head_r  <= start_head_r;
      mov_r   <= '0;
    end else if (cmd.scan_cmp && below_head) begin
      split_r <= split_r + CNT_W'(1);
    end
    if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.seg_asc) begin
      idx_r <= split_r;
    end else if (cmd.seg_desc) begin
      idx_r <= split_r - CNT_W'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CNT_W'(1);
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - CNT_W'(1);
    end
    if (cmd.vis_load || cmd.vis_end) begin
      head_r     <= vis_pos;
      mov_r      <= mov_r + sds_pkg::MOV_W'(seek_len);
      out_pos_r  <= vis_pos;
      out_end_r  <= cmd.vis_end;
      out_mov_r  <= mov_r + sds_pkg::MOV_W'(seek_len);
      out_last_r <= cmd.vis_final;
    end
  end

  assign sts.count_zero = (count_r == '0);
  assign sts.count_full = (count_r == CNT_MAX);
  assign sts.pos_one    = (pos_r == IDX_W'(1));
  assign sts.rdata_gt_v = (rdata_r > v_r);
  assign sts.last_req   = last_r;
  assign sts.split_zero = (split_r == '0);
  assign sts.split_full = (split_r == count_r);
  assign sts.idx_top    = (idx_r == count_m1);
  assign sts.idx_zero   = (idx_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.sweep_up   = sweep_up_r;

  assign out_valid = out_valid_r;
  assign out_pos   = out_pos_r;
  assign out_end   = out_end_r;
  assign out_mov   = out_mov_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

[rtl/sds_ctrl.sv]
// ----------------------------------------------------------------------------
// sds_ctrl: SCAN scheduler controller
// Sequences insertion sort, split search and the two sweeps of a schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire sds_pkg::sts_t  sts,
  output sds_pkg::cmd_t       cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_SHIFT    = 12'b0000_0000_0010,
    S_PLACE    = 12'b0000_0000_0100,
    S_DECIDE   = 12'b0000_0000_1000,
    S_SCAN_RD  = 12'b0000_0001_0000,
    S_SCAN_CMP = 12'b0000_0010_0000,
    S_SEG1     = 12'b0000_0100_0000,
    S_P1_RD    = 12'b0000_1000_0000,
    S_P1_EM    = 12'b0001_0000_0000,
    S_END_STOP = 12'b0010_0000_0000,
    S_P3_RD    = 12'b0100_0000_0000,
    S_P3_EM    = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   p1_last, p3_last;

  // first sweep runs with the configured direction, the return sweep against it
  assign p1_last = sts.sweep_up ? sts.idx_top  : sts.idx_zero;
  assign p3_last = sts.sweep_up ? sts.idx_zero : sts.idx_top;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ins_start = 1'b1;
          if (sts.count_full) begin
            state_nxt = S_DECIDE;
          end else if (sts.count_zero) begin
            state_nxt = S_PLACE;
          end else begin
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (sts.rdata_gt_v) begin
          cmd.ins_shift = 1'b1;
          if (sts.pos_one) begin
            state_nxt = S_PLACE;
          end
        end else begin
          cmd.ins_place = 1'b1;
          state_nxt     = S_DECIDE;
        end
      end
      S_PLACE: begin
        cmd.ins_place = 1'b1;
        state_nxt     = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts.last_req) begin
          state_nxt = S_IDLE;
        end else if (sts.count_zero) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        if (sts.idx_top) begin
          state_nxt = S_SEG1;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SEG1: begin
        if (sts.sweep_up) begin
          if (!sts.split_full) begin
            cmd.seg_asc = 1'b1;
            state_nxt   = S_P1_RD;
          end else begin
            cmd.seg_desc = 1'b1;
            state_nxt    = S_P3_RD;
          end
        end else begin
          if (!sts.split_zero) begin
            cmd.seg_desc = 1'b1;
            state_nxt    = S_P1_RD;
          end else begin
            cmd.seg_asc = 1'b1;
            state_nxt   = S_P3_RD;
          end
        end
      end
      S_P1_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_P1_EM;
      end
      S_P1_EM: begin
        if (sts.out_free) begin
          cmd.vis_load = 1'b1;
          if (p1_last) begin
            state_nxt = S_END_STOP;
          end else begin
            cmd.idx_inc = sts.sweep_up;
            cmd.idx_dec = !sts.sweep_up;
            state_nxt   = S_P1_RD;
          end
        end
      end
      S_END_STOP: begin
        if (sts.out_free) begin
          cmd.vis_end = 1'b1;
          if (sts.sweep_up ? sts.split_zero : sts.split_full) begin
            cmd.vis_final = 1'b1;
            cmd.clear     = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.seg_desc = sts.sweep_up;
            cmd.seg_asc  = !sts.sweep_up;
            state_nxt    = S_P3_RD;
          end
        end
      end
      S_P3_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_P3_EM;
      end
      S_P3_EM: begin
        if (sts.out_free) begin
          cmd.vis_load = 1'b1;
          if (p3_last) begin
            cmd.vis_final = 1'b1;
            cmd.clear     = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.idx_inc = !sts.sweep_up;
            cmd.idx_dec = sts.sweep_up;
            state_nxt   = S_P3_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/scan_disk_scheduler_core.sv]
// Insertion: a request holds the input for the insertion walk over the N stored
//   entries (one memory step per cycle of the walk); no walk when the store is full.
// The next request is taken once the walk ends.
// A flagged last request adds a split search over the stored entries, then a read
//   and an emit step per request visit and an end stop step while the output is taken at once.
// Reset (synchronous, rst_n low): store emptied, registers to their reset values.
// ----------------------------------------------------------------------------
// scan_disk_scheduler_core: SCAN (elevator) disk scheduler
// Collects a batch of cylinder requests in sorted order and, on the request
// flagged last, emits the elevator service order with running head movement.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_disk_scheduler_core #(
  parameter int MAX_REQUESTS = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // request items
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire [sds_pkg::IN_DAT_W-1:0]          in_tdata,   // [11:0] request_cylinder
  input  wire                                  in_tlast,   // last_request
  // visit items
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [sds_pkg::OUT_DAT_W-1:0]        out_tdata,  // [11:0] served_position,
                                                           // [24:12] movement_so_far
  output logic                                 out_tuser,  // end_stop_visit
  output logic                                 out_tlast,  // last_visit
  // register writes
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [sds_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [sds_pkg::CFG_DAT_W-1:0]         cfg_data
);

  sds_pkg::cmd_t             cmd;
  sds_pkg::sts_t             sts;
  logic [sds_pkg::POS_W-1:0] out_pos;
  logic [sds_pkg::MOV_W-1:0] out_mov;

  // register writes never stall
  assign cfg_ready = 1'b1;

  // controller: sequences insertion, split search and both sweeps
  sds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: sorted store, counters, movement and the output register
  sds_dp #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_dat   (cfg_data),
    .req_cyl   (in_tdata[sds_pkg::POS_W-1:0]),
    .req_last  (in_tlast),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_pos   (out_pos),
    .out_end   (out_tuser),
    .out_mov   (out_mov),
    .out_last  (out_tlast)
  );

  // pack the visit: position low, movement above, zero fill to 32 bits
  assign out_tdata = {
    {(sds_pkg::OUT_DAT_W - sds_pkg::MOV_W - sds_pkg::POS_W){1'b0}}, out_mov, out_pos
  };

endmodule

`default_nettype wire

[rtl/sds_checker.sv]
// ----------------------------------------------------------------------------
// sds_checker: port-level checks of the SCAN disk scheduler
// Watches the handshakes of the top level and flags ordering slips.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_tvalid,
  input wire                            in_tready,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [sds_pkg::OUT_DAT_W-1:0]   out_tdata,
  input wire                            out_tuser,
  input wire                            out_tlast
);

  // reset leaves no visit pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("visit pending after reset");

  // accepting a request starts sorting work, so the next cycle takes nothing
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken during insertion");

  // no new request while a schedule is still being delivered
  a_no_req_mid_schedule: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("request taken in the middle of a schedule");

  // a stalled visit holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled visit changed");

endmodule

bind scan_disk_scheduler_core sds_checker u_sds_checker (.*);

`default_nettype wire
